FILE: sv/srcls_pkg.sv
// ----------------------------------------------------------------------------
// Swarm role classifier package
// Shared widths, codes, register map and the item, result and config types.
// ----------------------------------------------------------------------------
package srcls_pkg;

	localparam int COORD_BITS    = 24;
	localparam int RAD_W         = 23;
	localparam int CFG_CNT_W     = 10;
	localparam int ID_W          = 8;
	localparam int COUNT_MAX_DEF = 1023;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 32;
	localparam int REG_IDX_W     = 3;

	localparam logic [RAD_W-1:0] MIN_LEN_Q8 = RAD_W'(26);

	localparam logic [1:0] KIND_START    = 2'd0;
	localparam logic [1:0] KIND_FRONTIER = 2'd1;
	localparam logic [1:0] KIND_MEMBER   = 2'd2;
	localparam logic [1:0] KIND_RESERVED = 2'd3;

	localparam logic [1:0] MEMBER_UNKNOWN   = 2'd0;
	localparam logic [1:0] MEMBER_EXPLORER  = 2'd1;
	localparam logic [1:0] MEMBER_COLLECTOR = 2'd2;
	localparam logic [1:0] MEMBER_RESERVED  = 2'd3;

	localparam logic ROLE_EXPLORER  = 1'b0;
	localparam logic ROLE_COLLECTOR = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_FIXED_MODE     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FIXED_ROLE     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REGION_RADIUS  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CLUSTER_SIZE   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MIN_NEIGHBOURS = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MIN_ISLANDS    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MAX_TRAILS     = 3'd6;

	localparam logic [RAD_W-1:0] RADIUS_RESET  = RAD_W'(256);
	localparam logic [RAD_W-1:0] CLUSTER_RESET = RAD_W'(256);

	typedef struct packed {
		logic [1:0]                   kind;
		logic                         last;
		logic [ID_W-1:0]              node_id;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] box_min_x;
		logic signed [COORD_BITS-1:0] box_max_x;
		logic signed [COORD_BITS-1:0] box_min_y;
		logic signed [COORD_BITS-1:0] box_max_y;
		logic                         is_trail;
		logic [1:0]                   member_role;
	} item_t;

	typedef struct packed {
		logic                 role;
		logic [CFG_CNT_W-1:0] near_frontiers;
		logic [CFG_CNT_W-1:0] near_islands;
		logic [CFG_CNT_W-1:0] near_trails;
		logic                 collector_near;
	} result_t;

	typedef struct packed {
		logic                 fixed_mode;
		logic                 fixed_role;
		logic [RAD_W-1:0]     region_radius;
		logic [RAD_W-1:0]     cluster_size;
		logic [CFG_CNT_W-1:0] min_neighbours;
		logic [CFG_CNT_W-1:0] min_islands;
		logic [CFG_CNT_W-1:0] max_trails;
	} cfg_t;

endpackage

FILE: sv/srcls_regs.sv
// ----------------------------------------------------------------------------
// Swarm role classifier configuration registers
// APB-style register file holding the mode, radius, size and threshold settings.
// ----------------------------------------------------------------------------
module srcls_regs
	import srcls_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	cfg_t                 cfg_q;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fixed_mode     <= 1'b0;
			cfg_q.fixed_role     <= 1'b0;
			cfg_q.region_radius  <= RADIUS_RESET;
			cfg_q.cluster_size   <= CLUSTER_RESET;
			cfg_q.min_neighbours <= '0;
			cfg_q.min_islands    <= '0;
			cfg_q.max_trails     <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FIXED_MODE:     cfg_q.fixed_mode     <= pwdata[0];
				REG_FIXED_ROLE:     cfg_q.fixed_role     <= pwdata[0];
				REG_REGION_RADIUS:  cfg_q.region_radius  <= pwdata[RAD_W-1:0];
				REG_CLUSTER_SIZE:   cfg_q.cluster_size   <= pwdata[RAD_W-1:0];
				REG_MIN_NEIGHBOURS: cfg_q.min_neighbours <= pwdata[CFG_CNT_W-1:0];
				REG_MIN_ISLANDS:    cfg_q.min_islands    <= pwdata[CFG_CNT_W-1:0];
				REG_MAX_TRAILS:     cfg_q.max_trails     <= pwdata[CFG_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FIXED_MODE:     prdata = DATA_W'(cfg_q.fixed_mode);
			REG_FIXED_ROLE:     prdata = DATA_W'(cfg_q.fixed_role);
			REG_REGION_RADIUS:  prdata = DATA_W'(cfg_q.region_radius);
			REG_CLUSTER_SIZE:   prdata = DATA_W'(cfg_q.cluster_size);
			REG_MIN_NEIGHBOURS: prdata = DATA_W'(cfg_q.min_neighbours);
			REG_MIN_ISLANDS:    prdata = DATA_W'(cfg_q.min_islands);
			REG_MAX_TRAILS:     prdata = DATA_W'(cfg_q.max_trails);
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: sv/swarm_role_classifier_core.sv
// Timing: the last item of a query is registered in item_s1, then its result in result_q.
// Throughput: one item per cycle unless stalled; each item is classified by combinational logic
// between the input register and the count and result registers.
// The input stalls only while a last item waits behind a stalled result.
// Reset: arst_n clears the valid bits, counts and own position, and sets the
// registers to their defaults.
// ----------------------------------------------------------------------------
// Swarm role classifier core
// Counts frontiers, islands and trails near the drone, notes nearby collectors and assigns a role.
// ----------------------------------------------------------------------------
module swarm_role_classifier_core
	import srcls_pkg::*;
#(
	parameter int COUNT_MAX = COUNT_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	localparam int CNT_W = $clog2(COUNT_MAX + 1);
	localparam int CMP_W = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
	localparam int DW    = COORD_BITS + 1;
	localparam int MAG_W = (DW > RAD_W) ? DW : RAD_W;
	localparam int EXT_W = MAG_W + 1;
	localparam int SQ_W  = 2 * RAD_W;
	localparam int SUM_W = SQ_W + 1;

	localparam logic [CNT_W-1:0] CNT_MAX_V = CNT_W'(COUNT_MAX);

	cfg_t cfg;

	srcls_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c >= CNT_MAX_V) ? CNT_MAX_V : c + CNT_W'(1);
	endfunction

	function automatic logic [CFG_CNT_W-1:0] to_field(input logic [CNT_W-1:0] c);
		logic [CMP_W-1:0] e;
		e = CMP_W'(c);
		return e[CFG_CNT_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] abs_diff(input logic signed [EXT_W-1:0] a,
		input logic signed [EXT_W-1:0] b);
		logic signed [EXT_W-1:0] d;
		logic signed [EXT_W-1:0] n;
		d = a - b;
		n = -d;
		return d[EXT_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
	endfunction

	logic [RAD_W-1:0] r_eff;
	logic [RAD_W-1:0] cs_eff;
	logic [SQ_W-1:0]  rsq_q;

	assign r_eff  = (cfg.region_radius < MIN_LEN_Q8) ? MIN_LEN_Q8 : cfg.region_radius;
	assign cs_eff = (cfg.cluster_size < MIN_LEN_Q8) ? MIN_LEN_Q8 : cfg.cluster_size;

	logic  rdy1, go;
	logic  valid_s1;
	item_t item_s1;

	logic [ID_W-1:0]              own_id_q;
	logic signed [COORD_BITS-1:0] own_x_q, own_y_q;

	logic [MAG_W-1:0]        adx, ady;
	logic [RAD_W-1:0]        dx_c, dy_c;
	logic [SQ_W-1:0]         sqx_c, sqy_c;
	logic [SUM_W-1:0]        dist_sq;
	logic                    far_c, near_c, small_c, member_c;
	logic signed [EXT_W-1:0] side_x, side_y, side, cs_s;
	logic [CNT_W-1:0]        nf, ni, nt;
	logic                    nc;
	logic                    role_c;
	logic [CNT_W-1:0]        frontier_q, island_q, trail_q;
	logic                    collector_q;
	logic                    result_valid_q;
	result_t                 result_q;

	assign go   = valid_s1 && !(item_s1.last && result_valid_q && result_stall);
	assign rdy1 = !valid_s1 || go;

	assign item_stall   = !rdy1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		adx     = abs_diff(EXT_W'($signed(item_s1.pos_x)), EXT_W'(own_x_q));
		ady     = abs_diff(EXT_W'($signed(item_s1.pos_y)), EXT_W'(own_y_q));
		far_c   = (adx > MAG_W'(r_eff)) || (ady > MAG_W'(r_eff));
		dx_c    = adx[RAD_W-1:0];
		dy_c    = ady[RAD_W-1:0];
		sqx_c   = dx_c * dx_c;
		sqy_c   = dy_c * dy_c;
		dist_sq = {1'b0, sqx_c} + {1'b0, sqy_c};
		near_c  = !far_c && (dist_sq <= SUM_W'(rsq_q));
		side_x = EXT_W'($signed(item_s1.box_max_x)) - EXT_W'($signed(item_s1.box_min_x));
		side_y = EXT_W'($signed(item_s1.box_max_y)) - EXT_W'($signed(item_s1.box_min_y));
		side   = (side_x > side_y) ? side_x : side_y;
		cs_s   = $signed({1'b0, MAG_W'(cs_eff)});
		small_c  = (side <= cs_s);
		member_c = (item_s1.kind == KIND_MEMBER) && (item_s1.node_id != own_id_q) &&
			(item_s1.member_role == MEMBER_COLLECTOR);
		nf = frontier_q;
		ni = island_q;
		nt = trail_q;
		nc = collector_q;
		case (item_s1.kind)
			KIND_START: begin
				nf = '0;
				ni = '0;
				nt = '0;
				nc = 1'b0;
			end
			KIND_FRONTIER: begin
				if (near_c) begin
					nf = sat_inc(frontier_q);
					if (small_c) ni = sat_inc(island_q);
					if (item_s1.is_trail) nt = sat_inc(trail_q);
				end
			end
			KIND_MEMBER: begin
				if (member_c && near_c) nc = 1'b1;
			end
			default: ;
		endcase
		if (cfg.fixed_mode) begin
			role_c = cfg.fixed_role;
		end else if (nc) begin
			role_c = ROLE_EXPLORER;
		end else if ((CMP_W'(nf) >= CMP_W'(cfg.min_neighbours)) &&
			(CMP_W'(ni) < CMP_W'(cfg.min_islands)) &&
			(CMP_W'(nt) <= CMP_W'(cfg.max_trails))) begin
			role_c = ROLE_EXPLORER;
		end else begin
			role_c = ROLE_COLLECTOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			own_id_q       <= '0;
			own_x_q        <= '0;
			own_y_q        <= '0;
			frontier_q     <= '0;
			island_q       <= '0;
			trail_q        <= '0;
			collector_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= item_valid;
			if (go) begin
				if (item_s1.kind == KIND_START) begin
					own_id_q <= item_s1.node_id;
					own_x_q  <= item_s1.pos_x;
					own_y_q  <= item_s1.pos_y;
				end
				if (item_s1.last) begin
					frontier_q  <= '0;
					island_q    <= '0;
					trail_q     <= '0;
					collector_q <= 1'b0;
				end else begin
					frontier_q  <= nf;
					island_q    <= ni;
					trail_q     <= nt;
					collector_q <= nc;
				end
			end
			if (go && item_s1.last) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsq_q <= r_eff * r_eff;
		if (rdy1) item_s1 <= item;
		if (go && item_s1.last) begin
			result_q.role           <= role_c;
			result_q.near_frontiers <= to_field(nf);
			result_q.near_islands   <= to_field(ni);
			result_q.near_trails    <= to_field(nt);
			result_q.collector_near <= nc;
		end
	end

endmodule

FILE: sv/srcls_checker.sv
// ----------------------------------------------------------------------------
// Swarm role classifier checker
// Port-level assertions on flow control and role selection, bound to the core.
// ----------------------------------------------------------------------------
module srcls_checker
	import srcls_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic              pready,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input result_t           result
);

	logic cfg_wr;
	logic fixed_mode_q;
	logic fixed_role_q;

	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_mode_q <= 1'b0;
			fixed_role_q <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[ADDR_W-1:2] == REG_FIXED_MODE) fixed_mode_q <= pwdata[0];
			if (paddr[ADDR_W-1:2] == REG_FIXED_ROLE) fixed_role_q <= pwdata[0];
		end
	end

	// With no result waiting, the pipeline always has room for a new transfer.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("item stalled with no pending result");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_fixed_role: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fixed_mode_q |-> result.role == fixed_role_q)
		else $error("fixed mode role mismatch");

	a_collector_gives_explorer: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !fixed_mode_q && result.collector_near |->
		result.role == ROLE_EXPLORER)
		else $error("nearby collector did not give explorer");

endmodule

bind swarm_role_classifier_core srcls_checker u_srcls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.pready       (pready),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swarm role classifier testbench
// Sends directed and random queries through the item port, predicts each
// role and the neighbour counts, and compares every result transfer with it.
// ----------------------------------------------------------------------------
module testbench;
	import srcls_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [COORD_BITS-1:0] Q_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] Q_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	function automatic longint q_val(logic signed [COORD_BITS-1:0] v);
		return v;
	endfunction

	function automatic longint clamped_len(logic [RAD_W-1:0] v);
		return (v < MIN_LEN_Q8) ? longint'(MIN_LEN_Q8) : longint'(v);
	endfunction

	class role_scoreboard;
		cfg_t                         cfg;
		logic [ID_W-1:0]              own_id;
		logic signed [COORD_BITS-1:0] own_x;
		logic signed [COORD_BITS-1:0] own_y;
		logic [CFG_CNT_W-1:0]         frontiers;
		logic [CFG_CNT_W-1:0]         islands;
		logic [CFG_CNT_W-1:0]         trails;
		logic                         collector_seen;
		result_t                      expected_roles[$];
		int                           errors;
		int                           results_checked;
		int                           explorer_results;
		int                           saturated_results;

		function new();
			cfg.fixed_mode     = 1'b0;
			cfg.fixed_role     = ROLE_EXPLORER;
			cfg.region_radius  = RADIUS_RESET;
			cfg.cluster_size   = CLUSTER_RESET;
			cfg.min_neighbours = '0;
			cfg.min_islands    = '0;
			cfg.max_trails     = '0;
			own_id = '0;
			own_x = '0;
			own_y = '0;
			clear_counts();
		endfunction

		function void clear_counts();
			frontiers = '0;
			islands = '0;
			trails = '0;
			collector_seen = 1'b0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_FIXED_MODE:     cfg.fixed_mode = val[0];
				REG_FIXED_ROLE:     cfg.fixed_role = val[0];
				REG_REGION_RADIUS:  cfg.region_radius = val[RAD_W-1:0];
				REG_CLUSTER_SIZE:   cfg.cluster_size = val[RAD_W-1:0];
				REG_MIN_NEIGHBOURS: cfg.min_neighbours = val[CFG_CNT_W-1:0];
				REG_MIN_ISLANDS:    cfg.min_islands = val[CFG_CNT_W-1:0];
				REG_MAX_TRAILS:     cfg.max_trails = val[CFG_CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function bit in_region(logic signed [COORD_BITS-1:0] x,
		                       logic signed [COORD_BITS-1:0] y);
			longint r, dx, dy;
			r = clamped_len(cfg.region_radius);
			dx = q_val(x) - q_val(own_x);
			dy = q_val(y) - q_val(own_y);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dx > r || dy > r) return 1'b0;
			return dx * dx + dy * dy <= r * r;
		endfunction

		function logic [CFG_CNT_W-1:0] bump(logic [CFG_CNT_W-1:0] c);
			return (c >= COUNT_MAX_DEF) ? c : c + 1'b1;
		endfunction

		function void note_item(item_t it);
			longint sx, sy, side;
			result_t r;
			case (it.kind)
				KIND_START: begin
					own_id = it.node_id;
					own_x = it.pos_x;
					own_y = it.pos_y;
					clear_counts();
				end
				KIND_FRONTIER: begin
					if (in_region(it.pos_x, it.pos_y)) begin
						sx = q_val(it.box_max_x) - q_val(it.box_min_x);
						sy = q_val(it.box_max_y) - q_val(it.box_min_y);
						side = (sx > sy) ? sx : sy;
						frontiers = bump(frontiers);
						if (side <= clamped_len(cfg.cluster_size)) islands = bump(islands);
						if (it.is_trail) trails = bump(trails);
					end
				end
				KIND_MEMBER: begin
					if (it.node_id != own_id && it.member_role == MEMBER_COLLECTOR &&
					    in_region(it.pos_x, it.pos_y))
						collector_seen = 1'b1;
				end
				default: ;
			endcase
			if (it.last) begin
				if (cfg.fixed_mode)
					r.role = cfg.fixed_role;
				else if (collector_seen)
					r.role = ROLE_EXPLORER;
				else if (frontiers >= cfg.min_neighbours && islands < cfg.min_islands &&
				         trails <= cfg.max_trails)
					r.role = ROLE_EXPLORER;
				else
					r.role = ROLE_COLLECTOR;
				r.near_frontiers = frontiers;
				r.near_islands = islands;
				r.near_trails = trails;
				r.collector_near = collector_seen;
				expected_roles.push_back(r);
				clear_counts();
			end
		endfunction

		function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
			if (exp_v !== got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (expected_roles.size() == 0) begin
				$error("result transfer with no expected result pending");
				errors++;
				return;
			end
			exp_r = expected_roles.pop_front();
			compare_field("role", exp_r.role, got.role);
			compare_field("near_frontiers", exp_r.near_frontiers, got.near_frontiers);
			compare_field("near_islands", exp_r.near_islands, got.near_islands);
			compare_field("near_trails", exp_r.near_trails, got.near_trails);
			compare_field("collector_near", exp_r.collector_near, got.collector_near);
			results_checked++;
			if (exp_r.role == ROLE_EXPLORER) explorer_results++;
			if (exp_r.near_frontiers == COUNT_MAX_DEF) saturated_results++;
		endfunction

		function int pending();
			return expected_roles.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;

	role_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int items_sent;
	int cycle_count = 0;
	logic [ID_W-1:0]              cur_id;
	logic signed [COORD_BITS-1:0] cur_x;
	logic signed [COORD_BITS-1:0] cur_y;

	swarm_role_classifier_core #(
		.COUNT_MAX(COUNT_MAX_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) sb.note_item(item);
			if (result_valid && !result_stall) sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic item_t random_bits();
		logic [$bits(item_t)-1:0] raw;
		raw = $bits(item_t)'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
		return raw;
	endfunction

	function automatic item_t mk(logic [1:0] kind, logic last, logic [ID_W-1:0] id,
	                             logic signed [COORD_BITS-1:0] x,
	                             logic signed [COORD_BITS-1:0] y);
		item_t it;
		it = '0;
		it.kind = kind;
		it.last = last;
		it.node_id = id;
		it.pos_x = x;
		it.pos_y = y;
		return it;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] near_coord(
		logic signed [COORD_BITS-1:0] base);
		longint span;
		if ($urandom_range(7) == 0) return COORD_BITS'($urandom());
		span = 3 * clamped_len(sb.cfg.region_radius) / 2;
		return COORD_BITS'(q_val(base) + longint'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic longint pick_side(longint cs);
		case ($urandom_range(9))
			0: return -longint'($urandom_range(1, cs));
			1: return cs;
			2: return cs + 1;
			default: return longint'($urandom_range(0, 2 * cs));
		endcase
	endfunction

	function automatic item_t with_box(item_t it);
		longint cs, sx, sy;
		if ($urandom_range(9) == 0) return it;
		cs = clamped_len(sb.cfg.cluster_size);
		sx = pick_side(cs);
		sy = pick_side(cs);
		it.box_min_x = COORD_BITS'(q_val(it.pos_x) - sx / 2);
		it.box_max_x = COORD_BITS'(q_val(it.box_min_x) + sx);
		it.box_min_y = COORD_BITS'(q_val(it.pos_y) - sy / 2);
		it.box_max_y = COORD_BITS'(q_val(it.box_min_y) + sy);
		return it;
	endfunction

	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (it.kind == KIND_START) begin
			cur_id = it.node_id;
			cur_x = it.pos_x;
			cur_y = it.pos_y;
		end
		items_sent++;
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
	endtask

	task automatic configure(input logic fm, input logic fr, input int unsigned rad,
	                         input int unsigned cl, input int unsigned mn,
	                         input int unsigned mi, input int unsigned mt);
		reg_write(REG_FIXED_MODE, DATA_W'(fm));
		reg_write(REG_FIXED_ROLE, DATA_W'(fr));
		reg_write(REG_REGION_RADIUS, DATA_W'(rad));
		reg_write(REG_CLUSTER_SIZE, DATA_W'(cl));
		reg_write(REG_MIN_NEIGHBOURS, DATA_W'(mn));
		reg_write(REG_MIN_ISLANDS, DATA_W'(mi));
		reg_write(REG_MAX_TRAILS, DATA_W'(mt));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Items that end no query may still be in the pipeline after the last
	// result, so drain idles the item port and keeps waiting after that result.
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic random_query();
		item_t it;
		int n;
		n = $urandom_range(0, 10);
		if ($urandom_range(9) != 0) begin
			it = random_bits();
			it.kind = KIND_START;
			it.last = (n == 0) || ($urandom_range(19) == 0);
			send_item(it);
		end else if (n == 0) begin
			n = 1;
		end
		for (int i = 1; i <= n; i++) begin
			it = random_bits();
			case ($urandom_range(19))
				0, 1: ;
				2, 3, 4, 5, 6, 7: begin
					it.kind = KIND_MEMBER;
					it.pos_x = near_coord(cur_x);
					it.pos_y = near_coord(cur_y);
					if ($urandom_range(5) == 0) it.node_id = cur_id;
					if ($urandom_range(1) == 0) it.member_role = MEMBER_COLLECTOR;
					it.last = 1'b0;
				end
				default: begin
					it.kind = KIND_FRONTIER;
					it.pos_x = near_coord(cur_x);
					it.pos_y = near_coord(cur_y);
					it = with_box(it);
					it.last = 1'b0;
				end
			endcase
			if (i == n) it.last = 1'b1;
			send_item(it);
		end
	endtask

	task automatic random_queries(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) random_query();
	endtask

	// One long query sends more frontiers than the counters can hold, so all three saturate at their ceiling.
	task automatic saturate_counts();
		item_t it;
		it = random_bits();
		it.kind = KIND_START;
		it.last = 1'b0;
		send_item(it);
		for (int i = 0; i < 1030; i++) begin
			it = mk(KIND_FRONTIER, i == 1029, 8'd0, cur_x, cur_y);
			it.box_min_x = cur_x;
			it.box_max_x = cur_x;
			it.box_min_y = cur_y;
			it.box_max_y = cur_y;
			it.is_trail = 1'b1;
			send_item(it);
		end
	endtask

	initial begin
		item_t d;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		item = '0;
		send_idle_pct = 8;
		stall_pct = 82;
		items_sent = 0;
		cur_id = '0;
		cur_x = '0;
		cur_y = '0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Frontier and member before any start use the reset own position.
		d = mk(KIND_FRONTIER, 1'b0, 8'd0, 24'sd0, 24'sd0);
		d.is_trail = 1'b1;
		send_item(d);
		d = mk(KIND_MEMBER, 1'b1, 8'd5, 24'sd10, -24'sd10);
		d.member_role = MEMBER_COLLECTOR;
		send_item(d);
		d = mk(KIND_MEMBER, 1'b1, 8'd0, 24'sd0, 24'sd0);
		d.member_role = MEMBER_COLLECTOR;
		send_item(d);
		send_item(mk(KIND_START, 1'b1, 8'hFF, Q_MAX, Q_MAX));
		send_item(mk(KIND_RESERVED, 1'b1, 8'h3C, Q_MIN, Q_MAX));

		// Radius edges at the default radius and box sides around the cluster size.
		send_item(mk(KIND_START, 1'b0, 8'h80, 24'sd0, 24'sd0));
		d = mk(KIND_FRONTIER, 1'b0, 8'd0, 24'sd256, 24'sd0);
		d.box_min_x = -24'sd128;
		d.box_max_x = 24'sd128;
		send_item(d);
		send_item(mk(KIND_FRONTIER, 1'b0, 8'd0, 24'sd257, 24'sd0));
		d = mk(KIND_FRONTIER, 1'b0, 8'd0, 24'sd181, -24'sd181);
		d.box_max_y = 24'sd257;
		d.is_trail = 1'b1;
		send_item(d);
		send_item(mk(KIND_FRONTIER, 1'b0, 8'd0, -24'sd182, 24'sd181));
		d = mk(KIND_FRONTIER, 1'b0, 8'd0, 24'sd0, 24'sd0);
		d.box_min_x = 24'sd500;
		d.box_max_x = -24'sd500;
		d.box_min_y = 24'sd40;
		d.box_max_y = 24'sd20;
		send_item(d);
		d = mk(KIND_MEMBER, 1'b0, 8'h80, 24'sd0, 24'sd0);
		d.member_role = MEMBER_COLLECTOR;
		send_item(d);
		d = mk(KIND_MEMBER, 1'b0, 8'd1, 24'sd0, 24'sd0);
		d.member_role = MEMBER_RESERVED;
		send_item(d);
		d = mk(KIND_MEMBER, 1'b0, 8'd2, 24'sd0, 24'sd0);
		d.member_role = MEMBER_EXPLORER;
		send_item(d);
		send_item(mk(KIND_MEMBER, 1'b1, 8'd3, 24'sd0, 24'sd0));

		// Opposite corners of the coordinate range must never count as near.
		send_item(mk(KIND_START, 1'b0, 8'd0, Q_MIN, Q_MIN));
		d = mk(KIND_FRONTIER, 1'b0, 8'd0, Q_MAX, Q_MAX);
		d.box_min_x = Q_MIN;
		d.box_max_x = Q_MAX;
		send_item(d);
		d = mk(KIND_MEMBER, 1'b1, 8'd3, Q_MAX, Q_MIN);
		d.member_role = MEMBER_COLLECTOR;
		send_item(d);
		send_item(mk(KIND_START, 1'b0, 8'd1, Q_MAX, Q_MAX));
		send_item(mk(KIND_FRONTIER, 1'b0, 8'd0, Q_MIN, Q_MIN));
		d = mk(KIND_FRONTIER, 1'b1, 8'd0, Q_MAX, Q_MAX);
		d.box_min_x = Q_MIN;
		d.box_max_x = Q_MAX;
		d.box_min_y = Q_MAX;
		d.box_max_y = Q_MIN;
		d.is_trail = 1'b1;
		send_item(d);
		drain();

		configure(1'b0, ROLE_COLLECTOR, 25, 0, 2, 3, 1);
		random_queries(150);
		drain();
		configure(1'b1, ROLE_EXPLORER, 8388607, 8388607, 1023, 1023, 1023);
		random_queries(150);
		drain();

		send_idle_pct = 82;
		stall_pct = 8;
		configure(1'b0, ROLE_EXPLORER, 2000, 300, 1, 2, 2);
		saturate_counts();
		random_queries(120);
		drain();
		configure(1'b1, ROLE_COLLECTOR, 26, 26, 0, 0, 0);
		random_queries(150);
		drain();

		send_idle_pct = 0;
		stall_pct = 0;
		configure(1'b0, ROLE_EXPLORER, 4096, 1024, 3, 4, 1);
		random_queries(250);
		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d item transfers and %0d results (%0d explorer, %0d saturated),",
		         items_sent, sb.results_checked, sb.explorer_results, sb.saturated_results);
		$display("across six register settings and three idle and stall patterns.");
		if (sb.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
